// ----- sv/mrfp_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte update for the RTU frame parser.
`timescale 1ns / 1ps

package mrfp_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // position counter covers 3 header bytes, up to 255 data bytes, 2 CRC bytes
    localparam int unsigned POS_W = 9;

    // byte handed from the receive queue to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    // one reflected CRC-16 byte update, eight shift steps
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- sv/mrfp_fifo.sv -----
// Receive queue: small register FIFO that decouples byte intake from parsing.
`timescale 1ns / 1ps

module mrfp_fifo #(
    parameter int unsigned DEPTH = mrfp_pkg::FIFO_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output mrfp_pkg::byte_item_t   head,
    input  logic                   pop
);
    import mrfp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             do_pop;

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= rx_byte;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty fifo");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fifo count missed a push");

endmodule

// ----- sv/mrfp_parser.sv -----
// Frame parser: per-byte state machine, CRC-16 check and registered result stage.
`timescale 1ns / 1ps

module mrfp_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrfp_pkg::byte_item_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 result_kind,
    output logic [7:0]           node_id,
    output logic [7:0]           function_code,
    output logic [15:0]          register_number,
    output logic [15:0]          word_value,
    output logic                 is_answer,
    output logic                 crc_ok,
    output logic [15:0]          computed_crc,
    output logic [15:0]          received_crc
);
    import mrfp_pkg::*;

    // parse state
    logic             answer_mode_reg, answer_mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       node_reg, node_next;
    logic [7:0]       func_reg, func_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      crc_hold_reg, crc_hold_next;
    logic [7:0]       pending_reg, pending_next;
    logic [6:0]       widx_reg, widx_next;

    // result stage
    logic             out_valid_reg;
    logic             kind_reg, kind_next;
    logic [7:0]       o_node_reg, o_func_reg;
    logic [15:0]      o_regnum_reg, o_regnum_next;
    logic [15:0]      o_value_reg, o_value_next;
    logic             o_answer_reg, o_answer_next;
    logic             o_ok_reg, o_ok_next;
    logic [15:0]      o_comp_reg, o_comp_next;
    logic [15:0]      o_recv_reg, o_recv_next;

    logic             fire;
    logic             emit;
    logic [7:0]       b;
    logic [15:0]      crc_b;
    logic [15:0]      recv;
    logic [POS_W-1:0] data_end;

    assign fire  = head.valid && (!out_valid_reg || out_ready);
    assign pop   = fire;
    assign b     = head.data;
    assign crc_b = crc_update(crc_reg, b);
    assign recv  = {b, pending_reg};
    assign data_end = POS_W'(count_reg[7:0]) + POS_W'(3);

    always_comb
    begin
        answer_mode_next = answer_mode_reg;
        pos_next         = pos_reg;
        node_next        = node_reg;
        func_next        = func_reg;
        start_next       = start_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        crc_hold_next    = crc_hold_reg;
        pending_next     = pending_reg;
        widx_next        = widx_reg;
        emit             = 1'b0;
        kind_next        = KIND_WORD;
        o_regnum_next    = start_reg;
        o_value_next     = count_reg;
        o_answer_next    = answer_mode_reg;
        o_ok_next        = 1'b0;
        o_comp_next      = '0;
        o_recv_next      = '0;

        if (pos_reg == POS_W'(0))
        begin
            node_next = b;
            crc_next  = crc_update(CRC_INIT, b);
            pos_next  = POS_W'(1);
        end
        else if (pos_reg == POS_W'(1))
        begin
            func_next = b;
            crc_next  = crc_b;
            pos_next  = POS_W'(2);
        end
        else if (!answer_mode_reg)
        begin
            unique case (pos_reg)
                POS_W'(2), POS_W'(4):
                begin
                    pending_next = b;
                    crc_next     = crc_b;
                    pos_next     = pos_reg + 1'b1;
                end
                POS_W'(3):
                begin
                    start_next = {pending_reg, b};
                    crc_next   = crc_b;
                    pos_next   = POS_W'(4);
                end
                POS_W'(5):
                begin
                    count_next = {pending_reg, b};
                    crc_next   = crc_b;
                    pos_next   = POS_W'(6);
                end
                POS_W'(6):
                begin
                    crc_hold_next = crc_reg;
                    pending_next  = b;
                    pos_next      = POS_W'(7);
                end
                default:
                begin
                    emit             = 1'b1;
                    kind_next        = KIND_SUMMARY;
                    o_regnum_next    = start_reg;
                    o_value_next     = count_reg;
                    o_answer_next    = 1'b0;
                    o_ok_next        = (crc_hold_reg == recv);
                    o_comp_next      = crc_hold_reg;
                    o_recv_next      = recv;
                    answer_mode_next = 1'b1;
                    pos_next         = '0;
                end
            endcase
        end
        else if (pos_reg == POS_W'(2))
        begin
            crc_next = crc_b;
            pos_next = POS_W'(3);
            if (b == 8'h00)
            begin
                // zero byte count: not an answer, continue as request
                answer_mode_next = 1'b0;
                pending_next     = 8'h00;
            end
            else
            begin
                count_next = {8'h00, b};
                widx_next  = '0;
            end
        end
        else if (pos_reg < data_end)
        begin
            crc_next = crc_b;
            pos_next = pos_reg + 1'b1;
            if (pos_reg[0])
                pending_next = b;
            else
            begin
                emit          = 1'b1;
                kind_next     = KIND_WORD;
                o_regnum_next = start_reg + {9'd0, widx_reg};
                o_value_next  = {pending_reg, b};
                o_answer_next = 1'b1;
                widx_next     = widx_reg + 1'b1;
            end
        end
        else if (pos_reg == data_end)
        begin
            crc_hold_next = crc_reg;
            pending_next  = b;
            pos_next      = pos_reg + 1'b1;
        end
        else
        begin
            emit             = 1'b1;
            kind_next        = KIND_SUMMARY;
            o_regnum_next    = start_reg;
            o_value_next     = {8'h00, count_reg[7:0]};
            o_answer_next    = 1'b1;
            o_ok_next        = (crc_hold_reg == recv);
            o_comp_next      = crc_hold_reg;
            o_recv_next      = recv;
            answer_mode_next = 1'b0;
            pos_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_mode_reg <= 1'b0;
            pos_reg         <= '0;
            node_reg        <= '0;
            func_reg        <= '0;
            start_reg       <= '0;
            count_reg       <= '0;
            crc_reg         <= CRC_INIT;
            crc_hold_reg    <= CRC_INIT;
            pending_reg     <= '0;
            widx_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                answer_mode_reg <= answer_mode_next;
                pos_reg         <= pos_next;
                node_reg        <= node_next;
                func_reg        <= func_next;
                start_reg       <= start_next;
                count_reg       <= count_next;
                crc_reg         <= crc_next;
                crc_hold_reg    <= crc_hold_next;
                pending_reg     <= pending_next;
                widx_reg        <= widx_next;
            end
            if (fire && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg     <= kind_next;
            o_node_reg   <= node_reg;
            o_func_reg   <= func_reg;
            o_regnum_reg <= o_regnum_next;
            o_value_reg  <= o_value_next;
            o_answer_reg <= o_answer_next;
            o_ok_reg     <= o_ok_next;
            o_comp_reg   <= o_comp_next;
            o_recv_reg   <= o_recv_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign node_id         = o_node_reg;
    assign function_code   = o_func_reg;
    assign register_number = o_regnum_reg;
    assign word_value      = o_value_reg;
    assign is_answer       = o_answer_reg;
    assign crc_ok          = o_ok_reg;
    assign computed_crc    = o_comp_reg;
    assign received_crc    = o_recv_reg;

    // 255 data bytes put the second CRC byte at position 259
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(259))
        else $error("frame position out of range");
    a_req_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !answer_mode_reg |-> pos_reg <= POS_W'(7))
        else $error("request position past trailer");
    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_WORD) |->
            (o_answer_reg && !o_ok_reg && o_comp_reg == '0 && o_recv_reg == '0))
        else $error("data word carries summary fields");
    a_summary_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && kind_next == KIND_SUMMARY) |=> pos_reg == '0)
        else $error("frame did not restart after summary");

endmodule

// ----- sv/modbus_rtu_frame_parser.sv -----
// Top level of the Modbus RTU frame parser: receive queue feeding the frame parser.
`timescale 1ns / 1ps

// Passive Modbus RTU frame parser. Bytes sniffed from the bus enter on the
// rx_byte channel, one per transaction, and are parsed alternately as a request
// (ID, function, start register, register count, CRC) and an answer (ID,
// function, byte count N, N data bytes, CRC), starting with a request after
// reset. Each full data word of an answer comes out as one result transaction
// (result_kind 0) numbered from the start register of the preceding request;
// the second CRC byte of every frame produces a summary (result_kind 1) with
// the CRC-16/Modbus check. An answer with byte count zero is taken as a request.
// Rate: one byte per clock sustained while out_ready is high. The byte-wide CRC
// update and position decode sit between the queue head and the result
// register; the result register is a single stage, so a stalled out_ready
// backs bytes up into the FIFO_DEPTH-entry receive queue, which keeps in_ready
// high until it fills. A byte that completes a result is registered in the
// receive queue and then in the result register, which raises out_valid.

module modbus_rtu_frame_parser #(
    parameter int unsigned FIFO_DEPTH = mrfp_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  node_id,
    output logic [7:0]  function_code,
    output logic [15:0] register_number,
    output logic [15:0] word_value,
    output logic        is_answer,
    output logic        crc_ok,
    output logic [15:0] computed_crc,
    output logic [15:0] received_crc
);
    import mrfp_pkg::*;

    byte_item_t head;
    logic       pop;

    // front: byte intake queue
    mrfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .head     (head),
        .pop      (pop)
    );

    // back: frame state, CRC and result register
    mrfp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .node_id         (node_id),
        .function_code   (function_code),
        .register_number (register_number),
        .word_value      (word_value),
        .is_answer       (is_answer),
        .crc_ok          (crc_ok),
        .computed_crc    (computed_crc),
        .received_crc    (received_crc)
    );

endmodule
